/* rtl/ufss_pkg.sv */
// Shared types and codes for the fair-share scheduler.
package ufss_pkg;

    localparam int unsigned ID_W   = 10;
    localparam int unsigned USER_W = 3;
    localparam int unsigned PRI_W  = 8;
    localparam int unsigned STAT_W = 3;
    localparam int unsigned TOT_W  = 32;

    localparam logic [1:0] OP_SCHED  = 2'd0;
    localparam logic [1:0] OP_ADD    = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;

    localparam logic [STAT_W-1:0] ST_CHOSEN   = 3'd0;
    localparam logic [STAT_W-1:0] ST_DONE     = 3'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY    = 3'd2;
    localparam logic [STAT_W-1:0] ST_FULL     = 3'd3;
    localparam logic [STAT_W-1:0] ST_NOTFOUND = 3'd4;

    localparam int unsigned CMD_W = 5;
    localparam logic [CMD_W-1:0] C_NOP      = 5'd0;
    localparam logic [CMD_W-1:0] C_LOAD     = 5'd1;
    localparam logic [CMD_W-1:0] C_ADD      = 5'd2;
    localparam logic [CMD_W-1:0] C_UPD      = 5'd3;
    localparam logic [CMD_W-1:0] C_NOTFOUND = 5'd4;
    localparam logic [CMD_W-1:0] C_RD       = 5'd5;
    localparam logic [CMD_W-1:0] C_REM_CHK  = 5'd6;
    localparam logic [CMD_W-1:0] C_SCH_CHK  = 5'd7;
    localparam logic [CMD_W-1:0] C_SH_INIT  = 5'd8;
    localparam logic [CMD_W-1:0] C_SH_RD    = 5'd9;
    localparam logic [CMD_W-1:0] C_SH_WR    = 5'd10;
    localparam logic [CMD_W-1:0] C_REM_END  = 5'd11;
    localparam logic [CMD_W-1:0] C_SCH_END  = 5'd12;
    localparam logic [CMD_W-1:0] C_PICK     = 5'd13;
    localparam logic [CMD_W-1:0] C_PICK_END = 5'd14;
    localparam logic [CMD_W-1:0] C_SEL_CHK  = 5'd15;
    localparam logic [CMD_W-1:0] C_TICK     = 5'd16;
    localparam logic [CMD_W-1:0] C_EMIT     = 5'd17;

    typedef struct packed {
        logic [1:0]        operation;
        logic              yield_request;
        logic [ID_W-1:0]   task_id;
        logic [USER_W-1:0] task_user;
        logic [PRI_W-1:0]  task_priority;
    } t_in_item;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [ID_W-1:0]   run_task_id;
        logic [PRI_W-1:0]  slices_left;
    } t_out_item;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [USER_W-1:0] user;
        logic [PRI_W-1:0]  pri;
    } t_entry;

    typedef struct packed {
        logic [CMD_W-1:0] code;
    } t_cmd;

    typedef struct packed {
        logic [1:0] op;
        logic       scan_end;
        logic       sh_end;
        logic       match;
        logic       found;
        logic       reselect;
        logic       pick_last;
        logic       any;
        logic       sel_match;
        logic       out_free;
    } t_dp_status;

endpackage

/* rtl/ufss_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module ufss_ram #(
    parameter int unsigned WIDTH = 21,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

/* rtl/ufss_ctrl.sv */
// Sequencer for the scheduler: issues one datapath command per cycle.
module ufss_ctrl
    import ufss_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  t_dp_status i_status,
    output t_cmd       o_cmd,
    output logic       o_in_stall
);
    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_DISP     = 4'd1;
    localparam logic [3:0] S_REM_RD   = 4'd2;
    localparam logic [3:0] S_REM_CHK  = 4'd3;
    localparam logic [3:0] S_SCH_RD   = 4'd4;
    localparam logic [3:0] S_SCH_CHK  = 4'd5;
    localparam logic [3:0] S_MOVE     = 4'd6;
    localparam logic [3:0] S_SH_TEST  = 4'd7;
    localparam logic [3:0] S_SH_WR    = 4'd8;
    localparam logic [3:0] S_PICK     = 4'd9;
    localparam logic [3:0] S_PICK_END = 4'd10;
    localparam logic [3:0] S_SEL_RD   = 4'd11;
    localparam logic [3:0] S_SEL_CHK  = 4'd12;
    localparam logic [3:0] S_FIN      = 4'd13;

    logic [3:0] r_state, n_state;
    t_cmd       cmd;

    always_comb begin
        n_state  = r_state;
        cmd.code = C_NOP;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.code = C_LOAD;
                    n_state  = S_DISP;
                end
            end
            S_DISP: begin
                case (i_status.op)
                    OP_ADD: begin
                        cmd.code = C_ADD;
                        n_state  = S_FIN;
                    end
                    OP_REMOVE: n_state = S_REM_RD;
                    OP_SCHED: begin
                        if (i_status.reselect) begin
                            n_state = S_SCH_RD;
                        end else begin
                            cmd.code = C_TICK;
                            n_state  = S_FIN;
                        end
                    end
                    default: begin
                        cmd.code = C_UPD;
                        n_state  = S_FIN;
                    end
                endcase
            end
            S_REM_RD: begin
                if (i_status.scan_end) begin
                    cmd.code = C_NOTFOUND;
                    n_state  = S_FIN;
                end else begin
                    cmd.code = C_RD;
                    n_state  = S_REM_CHK;
                end
            end
            S_REM_CHK: begin
                cmd.code = C_REM_CHK;
                n_state  = i_status.match ? S_SH_TEST : S_REM_RD;
            end
            S_SCH_RD: begin
                if (i_status.scan_end) begin
                    n_state = S_MOVE;
                end else begin
                    cmd.code = C_RD;
                    n_state  = S_SCH_CHK;
                end
            end
            S_SCH_CHK: begin
                cmd.code = C_SCH_CHK;
                n_state  = S_SCH_RD;
            end
            S_MOVE: begin
                if (i_status.found) begin
                    cmd.code = C_SH_INIT;
                    n_state  = S_SH_TEST;
                end else begin
                    n_state = S_PICK;
                end
            end
            S_SH_TEST: begin
                if (!i_status.sh_end) begin
                    cmd.code = C_SH_RD;
                    n_state  = S_SH_WR;
                end else if (i_status.op == OP_REMOVE) begin
                    cmd.code = C_REM_END;
                    n_state  = S_FIN;
                end else begin
                    cmd.code = C_SCH_END;
                    n_state  = S_PICK;
                end
            end
            S_SH_WR: begin
                cmd.code = C_SH_WR;
                n_state  = S_SH_TEST;
            end
            S_PICK: begin
                cmd.code = C_PICK;
                if (i_status.pick_last) begin
                    n_state = S_PICK_END;
                end
            end
            S_PICK_END: begin
                cmd.code = C_PICK_END;
                n_state  = i_status.any ? S_SEL_RD : S_FIN;
            end
            S_SEL_RD: begin
                cmd.code = C_RD;
                n_state  = S_SEL_CHK;
            end
            S_SEL_CHK: begin
                cmd.code = C_SEL_CHK;
                n_state  = i_status.sel_match ? S_FIN : S_SEL_RD;
            end
            S_FIN: begin
                if (i_status.out_free) begin
                    cmd.code = C_EMIT;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cmd      = cmd;
    assign o_in_stall = (r_state != S_IDLE);
endmodule

/* rtl/ufss_dp.sv */
// Scheduler datapath: run queue, scan counters, user totals and result register.
module ufss_dp
    import ufss_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 64,
    parameter int unsigned NUM_USERS   = 5
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cmd       i_cmd,
    input  t_in_item   i_in_item,
    input  logic       i_out_stall,
    output t_dp_status o_status,
    output logic       o_out_valid,
    output t_out_item  o_out_item
);
    localparam int unsigned AW = $clog2(QUEUE_DEPTH);
    localparam int unsigned LW = AW + 1;
    localparam int unsigned UW = (NUM_USERS > 1) ? $clog2(NUM_USERS) : 1;

    t_in_item             r_in;
    logic [LW-1:0]        r_len;
    logic [LW-1:0]        r_idx;
    logic [LW-1:0]        r_pos;
    logic                 r_found;
    t_entry               r_cur;
    logic [NUM_USERS-1:0] r_present;
    logic [UW-1:0]        r_ucnt;
    logic [UW-1:0]        r_best;
    logic [TOT_W-1:0]     r_best_tot;
    logic                 r_any;
    logic [ID_W-1:0]      r_cur_task;
    logic                 r_runnable;
    logic [PRI_W-1:0]     r_slice;
    logic [TOT_W-1:0]     r_total [NUM_USERS];
    t_out_item            r_res;
    t_out_item            r_out;
    logic                 r_out_valid;

    logic                 we;
    logic [AW-1:0]        waddr;
    t_entry               wdata;
    logic [AW-1:0]        raddr;
    t_entry               rdata;
    logic [LW-1:0]        idx_inc;
    logic [USER_W-1:0]    add_user;
    logic [PRI_W-1:0]     add_pri;
    logic [TOT_W:0]       tot_sum;
    logic [UW-1:0]        cur_u;
    logic [UW-1:0]        rd_u;

    assign idx_inc  = r_idx + LW'(1);
    assign add_user = (32'(r_in.task_user) >= NUM_USERS) ? USER_W'(NUM_USERS - 1)
                                                          : r_in.task_user;
    assign add_pri  = (r_in.task_priority == '0) ? PRI_W'(1) : r_in.task_priority;
    assign cur_u    = UW'(r_cur.user);
    assign rd_u     = UW'(rdata.user);
    assign tot_sum  = {1'b0, r_total[cur_u]} + (TOT_W + 1)'(r_cur.pri);

    always_comb begin
        we    = 1'b0;
        waddr = r_len[AW-1:0];
        wdata = '{id: r_in.task_id, user: add_user, pri: add_pri};
        raddr = (i_cmd.code == C_SH_RD) ? idx_inc[AW-1:0] : r_idx[AW-1:0];
        case (i_cmd.code)
            C_ADD: we = (r_len < LW'(QUEUE_DEPTH));
            C_SH_WR: begin
                we    = 1'b1;
                waddr = r_idx[AW-1:0];
                wdata = rdata;
            end
            C_SCH_END: begin
                we    = 1'b1;
                waddr = AW'(r_len - LW'(1));
                wdata = r_cur;
            end
            default: we = 1'b0;
        endcase
    end

    ufss_ram #(.WIDTH($bits(t_entry)), .DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= '0;
            r_cur_task  <= '0;
            r_runnable  <= 1'b0;
            r_slice     <= '0;
            r_out_valid <= 1'b0;
            for (int u = 0; u < NUM_USERS; u++) begin
                r_total[u] <= '0;
            end
        end else begin
            if (i_cmd.code == C_EMIT) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (i_cmd.code)
                C_ADD: begin
                    if (r_len < LW'(QUEUE_DEPTH)) begin
                        r_len <= r_len + LW'(1);
                    end
                end
                C_REM_END: begin
                    r_len <= r_len - LW'(1);
                    if (r_in.task_id == r_cur_task) begin
                        r_runnable <= 1'b0;
                    end
                end
                C_SCH_END: begin
                    r_total[cur_u] <= tot_sum[TOT_W] ? '1 : tot_sum[TOT_W-1:0];
                end
                C_PICK_END: begin
                    if (!r_any) begin
                        r_runnable <= 1'b0;
                        r_slice    <= '0;
                    end
                end
                C_SEL_CHK: begin
                    if (rd_u == r_best) begin
                        r_cur_task <= rdata.id;
                        r_slice    <= rdata.pri - PRI_W'(1);
                        r_runnable <= 1'b1;
                    end
                end
                C_TICK: r_slice <= r_slice - PRI_W'(1);
                default: r_len <= r_len;
            endcase
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.code == C_EMIT) begin
            r_out <= r_res;
        end
        case (i_cmd.code)
            C_LOAD: begin
                r_in      <= i_in_item;
                r_idx     <= '0;
                r_found   <= 1'b0;
                r_present <= '0;
                r_ucnt    <= '0;
                r_any     <= 1'b0;
            end
            C_ADD: begin
                r_res <= '{status: (r_len < LW'(QUEUE_DEPTH)) ? ST_DONE : ST_FULL,
                           run_task_id: '0, slices_left: '0};
            end
            C_UPD, C_REM_END: r_res <= '{status: ST_DONE, run_task_id: '0, slices_left: '0};
            C_NOTFOUND: r_res <= '{status: ST_NOTFOUND, run_task_id: '0, slices_left: '0};
            C_REM_CHK: begin
                if (rdata.id == r_in.task_id) begin
                    r_pos   <= r_idx;
                    r_found <= 1'b1;
                end else begin
                    r_idx <= idx_inc;
                end
            end
            C_SCH_CHK: begin
                r_present[rd_u] <= 1'b1;
                if (r_runnable && !r_found && rdata.id == r_cur_task) begin
                    r_found <= 1'b1;
                    r_pos   <= r_idx;
                    r_cur   <= rdata;
                end
                r_idx <= idx_inc;
            end
            C_SH_INIT: r_idx <= r_pos;
            C_SH_WR:   r_idx <= idx_inc;
            C_PICK: begin
                if (r_present[r_ucnt] && (!r_any || r_total[r_ucnt] < r_best_tot)) begin
                    r_best     <= r_ucnt;
                    r_best_tot <= r_total[r_ucnt];
                    r_any      <= 1'b1;
                end
                r_ucnt <= r_ucnt + UW'(1);
            end
            C_PICK_END: begin
                r_idx <= '0;
                if (!r_any) begin
                    r_res <= '{status: ST_EMPTY, run_task_id: '0, slices_left: '0};
                end
            end
            C_SEL_CHK: begin
                if (rd_u == r_best) begin
                    r_res <= '{status: ST_CHOSEN, run_task_id: rdata.id,
                               slices_left: rdata.pri - PRI_W'(1)};
                end else begin
                    r_idx <= idx_inc;
                end
            end
            C_TICK: begin
                r_res <= '{status: ST_CHOSEN, run_task_id: r_cur_task,
                           slices_left: r_slice - PRI_W'(1)};
            end
            default: r_idx <= r_idx;
        endcase
    end

    assign o_status.op        = r_in.operation;
    assign o_status.scan_end  = (r_idx >= r_len);
    assign o_status.sh_end    = (idx_inc >= r_len);
    assign o_status.match     = (rdata.id == r_in.task_id);
    assign o_status.found     = r_found;
    assign o_status.reselect  = r_in.yield_request || (r_slice == '0) || !r_runnable;
    assign o_status.pick_last = (r_ucnt == UW'(NUM_USERS - 1));
    assign o_status.any       = r_any;
    assign o_status.sel_match = (rd_u == r_best);
    assign o_status.out_free  = !r_out_valid || !i_out_stall;

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;
endmodule

/* rtl/user_fair_share_scheduler_top.sv */
// Top level of the fair-share round-robin task scheduler.
//
// Input channel i_in_valid / o_in_stall carries one t_in_item: schedule,
// add or remove. Output channel o_out_valid / i_out_stall returns exactly
// one t_out_item per input item, in order.
// One item is processed at a time; o_in_stall is high from the cycle after
// a transfer until its result is loaded into the output register.
// An add or other update, and a schedule that keeps the current task, go
// straight to the result. A remove scans entries up to the match, then
// shifts each entry behind it forward. A reselecting schedule scans the
// queue for present users, moves the current task to the tail, searches
// the NUM_USERS totals for the minimum and reads entries up to the chosen
// task; the queue scans share the single read port of the run-queue RAM.
// Reset clears the queue length, current task, slice counter and user
// totals; the queue RAM itself is not cleared. While the receiver stalls,
// the result holds in the output register and a finished next item waits.
module user_fair_share_scheduler_top
    import ufss_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 64,
    parameter int unsigned NUM_USERS   = 5
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);
    t_cmd       cmd;
    t_dp_status status;

    ufss_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in_valid),
        .i_status  (status),
        .o_cmd     (cmd),
        .o_in_stall(o_in_stall)
    );

    ufss_dp #(.QUEUE_DEPTH(QUEUE_DEPTH), .NUM_USERS(NUM_USERS)) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_in_item  (i_in_item),
        .i_out_stall(i_out_stall),
        .o_status   (status),
        .o_out_valid(o_out_valid),
        .o_out_item (o_out_item)
    );
endmodule

/* rtl/ufss_checker.sv */
// Port-level checks for the scheduler top level, with its bind.
module ufss_checker
    import ufss_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_stall,
    input t_in_item  i_in_item,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_item o_out_item
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("stalled result changed");

    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken while an item is in flight");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_item.status <= ST_NOTFOUND)
        else $error("status code out of range");

    a_idle_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.status != ST_CHOSEN |->
            o_out_item.run_task_id == '0 && o_out_item.slices_left == '0)
        else $error("nonzero fields on a non-schedule result");
endmodule

bind user_fair_share_scheduler_top ufss_checker u_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_valid (i_in_valid),
    .o_in_stall (o_in_stall),
    .i_in_item  (i_in_item),
    .o_out_valid(o_out_valid),
    .i_out_stall(i_out_stall),
    .o_out_item (o_out_item)
);

/* test/tb.sv */
// Testbench for the fair-share round-robin task scheduler.
`timescale 1ns / 100ps

module tb;
    import ufss_pkg::*;

    localparam int QDEPTH = 64;
    localparam int NUSERS = 5;
    localparam longint CYCLE_LIMIT = 3000000;
    localparam logic [1:0] OP_UNKNOWN = 2'd3;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_stall;
    t_in_item  i_in_item;
    logic      o_out_valid;
    logic      i_out_stall;
    t_out_item o_out_item;

    user_fair_share_scheduler_top #(.QUEUE_DEPTH(QDEPTH), .NUM_USERS(NUSERS)) u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in_item(i_in_item),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out_item(o_out_item)
    );

    always begin
        i_clk = 1'b1; #1;
        i_clk = 1'b0; #1;
    end

    // scheduler shadow state
    t_entry      rq[$];
    logic [9:0]  cur_id;
    logic        cur_run;
    logic [7:0]  slice_cnt;
    logic [31:0] user_total[NUSERS];

    t_in_item  pending_items[$];
    t_out_item expected_results[$];
    int  errors;
    int  transfers_in, transfers_out;
    int  send_idle_pct, recv_idle_pct;
    longint cycles;

    function automatic int find_task(logic [9:0] id);
        for (int i = 0; i < rq.size(); i++)
            if (rq[i].id == id) return i;
        return -1;
    endfunction

    function automatic t_out_item schedule_step(t_in_item it);
        t_out_item r;
        t_entry e;
        bit present[NUSERS];
        int pos, best;
        bit any;
        logic [32:0] sum;
        r = '0;
        best = 0;
        any = 0;
        case (it.operation)
            OP_ADD: begin
                if (rq.size() >= QDEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    e.id = it.task_id;
                    e.user = (it.task_user >= NUSERS) ? 3'(NUSERS - 1) : it.task_user;
                    e.pri = (it.task_priority == 0) ? 8'd1 : it.task_priority;
                    rq.push_back(e);
                    r.status = ST_DONE;
                end
            end
            OP_REMOVE: begin
                pos = find_task(it.task_id);
                if (pos < 0) begin
                    r.status = ST_NOTFOUND;
                end else begin
                    rq.delete(pos);
                    if (it.task_id == cur_id) cur_run = 1'b0;
                    r.status = ST_DONE;
                end
            end
            OP_UNKNOWN: r.status = ST_DONE;
            default: begin
                if (it.yield_request || slice_cnt == 0 || !cur_run) begin
                    foreach (present[i]) present[i] = 0;
                    foreach (rq[i]) present[rq[i].user] = 1;
                    if (cur_run) begin
                        pos = find_task(cur_id);
                        if (pos >= 0) begin
                            e = rq[pos];
                            rq.delete(pos);
                            rq.push_back(e);
                            sum = {1'b0, user_total[e.user]} + e.pri;
                            user_total[e.user] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
                        end
                    end
                    for (int u = 0; u < NUSERS; u++)
                        if (present[u] && (!any || user_total[u] < user_total[best])) begin
                            best = u;
                            any = 1;
                        end
                    if (!any) begin
                        cur_run = 1'b0;
                        slice_cnt = '0;
                        r.status = ST_EMPTY;
                        return r;
                    end
                    for (int i = 0; i < rq.size(); i++)
                        if (rq[i].user == best) begin
                            cur_id = rq[i].id;
                            slice_cnt = rq[i].pri;
                            cur_run = 1'b1;
                            break;
                        end
                end
                if (slice_cnt > 0) slice_cnt--;
                r.status = ST_CHOSEN;
                r.run_task_id = cur_id;
                r.slices_left = slice_cnt;
            end
        endcase
        return r;
    endfunction

    function automatic t_in_item make_item(logic [1:0] op, logic y, logic [9:0] id,
                                           logic [2:0] u, logic [7:0] p);
        t_in_item it;
        it.operation = op;
        it.yield_request = y;
        it.task_id = id;
        it.task_user = u;
        it.task_priority = p;
        return it;
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!(i_in_valid && o_in_stall)) begin
            if (i_in_valid) begin
                expected_results.push_back(schedule_step(i_in_item));
                transfers_in++;
            end
            if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                i_in_item  <= pending_items.pop_front();
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        cycles++;
        if (i_rst_n) begin
            i_out_stall <= ($urandom_range(99) < recv_idle_pct);
            if (o_out_valid && !i_out_stall) begin
                transfers_out++;
                if (expected_results.size() == 0) begin
                    $error("result with nothing expected: %p", o_out_item);
                    errors++;
                end else begin
                    t_out_item x;
                    x = expected_results.pop_front();
                    if (x.status != o_out_item.status) begin
                        $error("status: expected %0d got %0d", x.status, o_out_item.status);
                        errors++;
                    end
                    if (x.run_task_id != o_out_item.run_task_id) begin
                        $error("run_task_id: expected %0d got %0d",
                               x.run_task_id, o_out_item.run_task_id);
                        errors++;
                    end
                    if (x.slices_left != o_out_item.slices_left) begin
                        $error("slices_left: expected %0d got %0d",
                               x.slices_left, o_out_item.slices_left);
                        errors++;
                    end
                end
            end
        end
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("Simulation FAILED");
            $finish;
        end
    end

    // random traffic: mostly adds/schedules on a small id pool so removes hit
    task automatic add_random(int n);
        int r;
        logic [9:0] id;
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(99);
            id = ($urandom_range(3) == 0) ? 10'($urandom) : 10'($urandom_range(40));
            if (r < 30)
                pending_items.push_back(make_item(OP_ADD, 1'($urandom), id,
                    3'($urandom), ($urandom_range(3) == 0) ? 8'($urandom)
                                                         : 8'($urandom_range(4))));
            else if (r < 45)
                pending_items.push_back(make_item(OP_REMOVE, 1'($urandom), id,
                    3'($urandom), 8'($urandom)));
            else if (r < 48)
                pending_items.push_back(make_item(OP_UNKNOWN, 1'($urandom), 10'($urandom),
                    3'($urandom), 8'($urandom)));
            else
                pending_items.push_back(make_item(OP_SCHED, ($urandom_range(4) == 0),
                    10'($urandom), 3'($urandom), 8'($urandom)));
        end
    endtask

    task automatic wait_drain();
        while (pending_items.size() > 0 || i_in_valid || expected_results.size() > 0)
            @(posedge i_clk);
    endtask

    initial begin
        errors = 0;
        cycles = 0;
        transfers_in = 0;
        transfers_out = 0;
        cur_id = '0;
        cur_run = 1'b0;
        slice_cnt = '0;
        foreach (user_total[i]) user_total[i] = '0;
        i_in_valid = 1'b0;
        i_out_stall = 1'b0;
        i_in_item = '0;
        send_idle_pct = 11;
        recv_idle_pct = 47;
        i_rst_n = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty queue, unknown op, edge fields, full queue, missing task
        pending_items.push_back(make_item(OP_SCHED, 1'b0, 10'd0, 3'd0, 8'd0));
        pending_items.push_back(make_item(OP_REMOVE, 1'b1, 10'd1023, 3'd7, 8'd255));
        pending_items.push_back(make_item(OP_UNKNOWN, 1'b1, 10'd1023, 3'd7, 8'd255));
        pending_items.push_back(make_item(OP_ADD, 1'b1, 10'd1023, 3'd7, 8'd0));
        pending_items.push_back(make_item(OP_ADD, 1'b0, 10'd0, 3'd0, 8'd255));
        pending_items.push_back(make_item(OP_ADD, 1'b0, 10'd5, 3'd2, 8'd2));
        pending_items.push_back(make_item(OP_ADD, 1'b0, 10'd5, 3'd5, 8'd1));
        pending_items.push_back(make_item(OP_SCHED, 1'b0, 10'd0, 3'd0, 8'd0));
        pending_items.push_back(make_item(OP_SCHED, 1'b0, 10'd0, 3'd0, 8'd0));
        pending_items.push_back(make_item(OP_SCHED, 1'b1, 10'd0, 3'd0, 8'd0));
        pending_items.push_back(make_item(OP_SCHED, 1'b0, 10'd0, 3'd0, 8'd0));
        pending_items.push_back(make_item(OP_REMOVE, 1'b0, 10'd5, 3'd0, 8'd0));
        pending_items.push_back(make_item(OP_SCHED, 1'b0, 10'd0, 3'd0, 8'd0));
        pending_items.push_back(make_item(OP_REMOVE, 1'b0, 10'd777, 3'd0, 8'd0));
        for (int i = 0; i < 66; i++)
            pending_items.push_back(make_item(OP_ADD, 1'b0, 10'(i), 3'(i), 8'(i * 37)));
        for (int i = 0; i < 66; i++)
            pending_items.push_back(make_item(OP_REMOVE, 1'b0, 10'(i), 3'd0, 8'd0));
        pending_items.push_back(make_item(OP_REMOVE, 1'b0, 10'd1023, 3'd0, 8'd0));
        pending_items.push_back(make_item(OP_SCHED, 1'b1, 10'd0, 3'd0, 8'd0));
        wait_drain();

        add_random(270);
        wait_drain();
        send_idle_pct = 47;
        recv_idle_pct = 11;
        add_random(270);
        wait_drain();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        add_random(262);
        wait_drain();
        repeat (500) @(posedge i_clk);

        $display("transfers: %0d items in, %0d results out, three idling profiles",
                 transfers_in, transfers_out);
        $display("covered add/remove/schedule, full and empty queue, yield, unknown op");
        if (errors == 0 && expected_results.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
